// File: design/kalman_angle_fusion_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the angle fusion filter
// Shared forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef KALMAN_ANGLE_FUSION_ASSERT_SVH
`define KALMAN_ANGLE_FUSION_ASSERT_SVH

// Same-cycle implication.
`define KAF_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define KAF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/kaf_pkg.sv
// ----------------------------------------------------------------------------
// kaf_pkg
// Types, widths and constants shared by the angle fusion filter modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kaf_pkg;

    typedef logic signed [39:0] wide_t;

    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 33;
    localparam int MUL_R_W = 36;
    localparam int MUL_ACC_W = 65;
    localparam int DIV_DEN_W = 34;
    localparam int DIV_Q_W = 62;

    localparam logic [31:0] ANGLE_NOISE_RST = 32'd1073742;
    localparam logic [31:0] BIAS_NOISE_RST = 32'd3221225;
    localparam logic [31:0] MEAS_NOISE_RST = 32'd536870912;
    localparam logic [30:0] PERIOD_RST = 31'd5368709;
    localparam logic [30:0] Q30_ONE_U = 31'h4000_0000;
    localparam logic signed [31:0] Q30_ONE_S = 32'sh4000_0000;

    localparam logic [1:0] REG_ANGLE_NOISE = 2'd0;
    localparam logic [1:0] REG_BIAS_NOISE = 2'd1;
    localparam logic [1:0] REG_MEAS_NOISE = 2'd2;
    localparam logic [1:0] REG_PERIOD = 2'd3;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_START = 5'b00010,
        ST_WAIT  = 5'b00100,
        ST_EMIT  = 5'b01000,
        ST_HOLD  = 5'b10000
    } state_t;

    // One entry per arithmetic step of a sample, in issue order.
    typedef enum logic [3:0] {
        OP_PRED = 4'd0,
        OP_CAA  = 4'd1,
        OP_CAB  = 4'd2,
        OP_CBB  = 4'd3,
        OP_K0   = 4'd4,
        OP_K1   = 4'd5,
        OP_UAA  = 4'd6,
        OP_UAB  = 4'd7,
        OP_UBA  = 4'd8,
        OP_UBB  = 4'd9,
        OP_FA   = 4'd10,
        OP_RB   = 4'd11
    } op_t;

    function automatic logic signed [31:0] sat32(input wide_t v);
        if (v > wide_t'(32'sh7fff_ffff))
            return 32'sh7fff_ffff;
        else if (v < -wide_t'(32'sh7fff_ffff) - wide_t'(1))
            return 32'sh8000_0000;
        else
            return v[31:0];
    endfunction

endpackage

// File: design/kalman_angle_fusion.sv
// ----------------------------------------------------------------------------
// kalman_angle_fusion
// Two-state Kalman filter fusing an accelerometer tilt angle with a gyro rate.
// ----------------------------------------------------------------------------
// Each sample (measured angle, gyro rate) runs through a fixed sequence of ten
// rounded Q30 multiplies on a bit-serial multiplier and two gain divisions on a
// restoring divider. A multiply step issues its operands, runs through the
// multiplier bits and captures the result; a division step runs through the
// quotient bits. The block takes one sample at a time; a finished result waits
// in the output register while the next sample is already being worked on, and
// only a result still waiting when the next one is done stalls the block.
// Configuration should only be written while no sample is in flight.
`timescale 1ns / 1ps
`include "kalman_angle_fusion_assert.svh"

module kalman_angle_fusion
    import kaf_pkg::*;
#(
    parameter int DATA_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // measured_angle [31:0], gyro_rate [63:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // angle_estimate [31:0], rate_estimate [63:32]
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_data
);

    localparam int SAT_W = (DATA_WIDTH < 16) ? 16 : ((DATA_WIDTH > 32) ? 32 : DATA_WIDTH);
    localparam wide_t SAT_MAX = (wide_t'(1) <<< (SAT_W - 1)) - wide_t'(1);
    localparam wide_t SAT_MIN = -SAT_MAX - wide_t'(1);

    function automatic logic signed [31:0] sat_data(input wide_t v);
        wide_t c;
        c = (v > SAT_MAX) ? SAT_MAX : ((v < SAT_MIN) ? SAT_MIN : v);
        return c[31:0];
    endfunction

    logic [31:0] qa_reg, qb_reg, mn_reg;
    logic [30:0] sp_reg;

    state_t state_reg;
    op_t    op_reg;

    logic signed [31:0] fa_reg, rb_reg, caa_reg, cab_reg, cba_reg, cbb_reg;
    logic signed [31:0] meas_reg, gyro_reg, pred_reg, err_reg, k0_reg, k1_reg;
    logic signed [31:0] t0_reg, t1_reg;
    logic signed [DIV_DEN_W-1:0] e_reg;
    logic [30:0] dt_reg;
    logic        m_tvalid_reg;
    logic [63:0] m_tdata_reg;

    logic                        mul_start, div_start;
    logic signed [MUL_A_W-1:0]   mul_a;
    logic signed [MUL_B_W-1:0]   mul_b;
    logic                        mul_busy, mul_done, div_busy, div_done;
    logic signed [MUL_R_W-1:0]   mul_r;
    logic signed [31:0]          div_num, div_q;
    logic                        is_div, unit_done, e_pos, emit_ok;
    wide_t                       r;
    logic signed [DIV_DEN_W-1:0] e_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign is_div    = (op_reg == OP_K0) || (op_reg == OP_K1);
    assign mul_start = (state_reg == ST_START) && !is_div;
    assign div_start = (state_reg == ST_START) && is_div;
    assign unit_done = is_div ? div_done : mul_done;
    assign r         = wide_t'(mul_r);
    assign e_pos     = !e_reg[DIV_DEN_W-1] && (e_reg != '0);
    assign e_next    = $signed({2'b00, mn_reg}) + DIV_DEN_W'(caa_reg);
    assign div_num   = (op_reg == OP_K0) ? caa_reg : cba_reg;
    assign emit_ok   = !m_tvalid_reg || m_tready;

    // Operand selection for each step of the sequence.
    always_comb
    begin
        wide_t a_w;
        a_w   = '0;
        mul_b = $signed({2'b00, dt_reg});
        case (op_reg)
            OP_PRED: a_w = wide_t'(sat32(wide_t'(gyro_reg) - wide_t'(rb_reg)));
            OP_CAA:  a_w = wide_t'(sat32($signed({8'd0, qa_reg})
                                         - wide_t'(cab_reg) - wide_t'(cba_reg)));
            OP_CAB:  a_w = -wide_t'(cbb_reg);
            OP_CBB:  a_w = $signed({8'd0, qb_reg});
            OP_UAA:  begin a_w = wide_t'(t0_reg); mul_b = MUL_B_W'(k0_reg); end
            OP_UAB:  begin a_w = wide_t'(t1_reg); mul_b = MUL_B_W'(k0_reg); end
            OP_UBA:  begin a_w = wide_t'(t0_reg); mul_b = MUL_B_W'(k1_reg); end
            OP_UBB:  begin a_w = wide_t'(t1_reg); mul_b = MUL_B_W'(k1_reg); end
            OP_FA:   begin a_w = wide_t'(err_reg); mul_b = MUL_B_W'(k0_reg); end
            OP_RB:   begin a_w = wide_t'(err_reg); mul_b = MUL_B_W'(k1_reg); end
            default: a_w = '0;
        endcase
        mul_a = a_w[MUL_A_W-1:0];
    end

    kaf_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .busy   (mul_busy),
        .done   (mul_done),
        .result (mul_r)
    );

    kaf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (e_reg),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qa_reg <= ANGLE_NOISE_RST;
            qb_reg <= BIAS_NOISE_RST;
            mn_reg <= MEAS_NOISE_RST;
            sp_reg <= PERIOD_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_ANGLE_NOISE: qa_reg <= cfg_data;
                REG_BIAS_NOISE:  qb_reg <= cfg_data;
                REG_MEAS_NOISE:  mn_reg <= cfg_data;
                REG_PERIOD:      sp_reg <= cfg_data[30:0];
                default:         ;
            endcase
        end
    end

    // A new result is loaded in the same cycle that a waiting one is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (state_reg == ST_EMIT && emit_ok)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            op_reg       <= OP_PRED;
            fa_reg       <= '0;
            rb_reg       <= '0;
            caa_reg      <= Q30_ONE_S;
            cab_reg      <= '0;
            cba_reg      <= '0;
            cbb_reg      <= Q30_ONE_S;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        state_reg <= ST_START;
                        op_reg    <= OP_PRED;
                    end
                end
                ST_START:
                    state_reg <= ST_WAIT;
                ST_WAIT:
                begin
                    if (unit_done)
                    begin
                        case (op_reg)
                            OP_CAA: caa_reg <= sat32(wide_t'(caa_reg) + r);
                            OP_CAB:
                            begin
                                cab_reg <= sat32(wide_t'(cab_reg) + r);
                                cba_reg <= sat32(wide_t'(cba_reg) + r);
                            end
                            OP_CBB: cbb_reg <= sat32(wide_t'(cbb_reg) + r);
                            OP_UAA: caa_reg <= sat32(wide_t'(caa_reg) - r);
                            OP_UAB: cab_reg <= sat32(wide_t'(cab_reg) - r);
                            OP_UBA: cba_reg <= sat32(wide_t'(cba_reg) - r);
                            OP_UBB: cbb_reg <= sat32(wide_t'(cbb_reg) - r);
                            OP_FA:  fa_reg  <= sat_data(wide_t'(pred_reg) + r);
                            OP_RB:  rb_reg  <= sat_data(wide_t'(rb_reg) + r);
                            default: ;
                        endcase
                        if (op_reg == OP_RB)
                            state_reg <= ST_EMIT;
                        else
                        begin
                            op_reg    <= op_t'(op_reg + 4'd1);
                            state_reg <= ST_START;
                        end
                    end
                end
                ST_EMIT:
                begin
                    if (emit_ok)
                        state_reg <= ST_HOLD;
                end
                ST_HOLD:
                    state_reg <= ST_IDLE;
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // Sample payload and intermediate values of the step sequence.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && s_tvalid)
        begin
            meas_reg <= $signed(s_tdata[31:0]);
            gyro_reg <= $signed(s_tdata[63:32]);
            dt_reg   <= (sp_reg > Q30_ONE_U) ? Q30_ONE_U : sp_reg;
        end
        if (state_reg == ST_WAIT && unit_done)
        begin
            case (op_reg)
                OP_PRED: pred_reg <= sat_data(wide_t'(fa_reg) + r);
                OP_CBB:
                begin
                    err_reg <= sat32(wide_t'(meas_reg) - wide_t'(pred_reg));
                    e_reg   <= e_next;
                    t0_reg  <= caa_reg;
                    t1_reg  <= cab_reg;
                end
                OP_K0: k0_reg <= e_pos ? div_q : '0;
                OP_K1: k1_reg <= e_pos ? div_q : '0;
                default: ;
            endcase
        end
        if (state_reg == ST_EMIT && emit_ok)
            m_tdata_reg <= {sat_data(wide_t'(gyro_reg) - wide_t'(rb_reg)), fa_reg};
    end

    `KAF_ASSERT_NEXT(a_accept_starts, s_tvalid && s_tready, state_reg == ST_START && op_reg == OP_PRED, "accepted sample did not start the sequence")
    `KAF_ASSERT_IMPLY(a_one_unit, mul_busy || div_busy, !(mul_busy && div_busy), "multiplier and divider busy together")
    `KAF_ASSERT_NEXT(a_gain_zero, state_reg == ST_WAIT && div_done && op_reg == OP_K0 && !e_pos, k0_reg == '0, "gain not cleared for non-positive innovation variance")

endmodule

// File: design/kaf_mul.sv
// ----------------------------------------------------------------------------
// kaf_mul
// Bit-serial signed multiplier with Q30 rounding, one multiplier bit a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kaf_mul
    import kaf_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic signed [MUL_A_W-1:0]   a,
    input  logic signed [MUL_B_W-1:0]   b,
    output logic                        busy,
    output logic                        done,
    output logic signed [MUL_R_W-1:0]   result
);

    logic [MUL_A_W-2:0]   a_reg;
    logic [MUL_B_W-2:0]   b_reg;
    logic [MUL_ACC_W-1:0] acc_reg;
    logic                 neg_reg;
    logic [4:0]           cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [MUL_A_W-1:0]   a_abs;
    logic [MUL_B_W-1:0]   b_abs;
    logic [MUL_A_W-1:0]   part_sum;
    logic [MUL_ACC_W-1:0] rounded;
    logic [MUL_R_W-2:0]   mag;

    assign a_abs = a[MUL_A_W-1] ? -a : a;
    assign b_abs = b[MUL_B_W-1] ? -b : b;
    assign part_sum = {1'b0, acc_reg[MUL_ACC_W-1:MUL_B_W-1]}
                    + (b_reg[0] ? {1'b0, a_reg} : '0);

    // Magnitude rounding gives ties away from zero once the sign is applied.
    assign rounded = acc_reg + (MUL_ACC_W'(1) << 29);
    assign mag = rounded[MUL_ACC_W-1:30];
    assign result = neg_reg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    assign busy = busy_reg;
    assign done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd31;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a_abs[MUL_A_W-2:0];
            b_reg   <= b_abs[MUL_B_W-2:0];
            acc_reg <= '0;
            neg_reg <= a[MUL_A_W-1] ^ b[MUL_B_W-1];
        end
        else if (busy_reg)
        begin
            acc_reg <= {part_sum, acc_reg[MUL_B_W-2:1]};
            b_reg   <= {1'b0, b_reg[MUL_B_W-2:1]};
        end
    end

endmodule

// File: design/kaf_div.sv
// ----------------------------------------------------------------------------
// kaf_div
// Restoring divider for the Kalman gains: (num << 30) / den, one bit a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kaf_div
    import kaf_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic signed [31:0]          num,
    input  logic signed [DIV_DEN_W-1:0] den,
    output logic                        busy,
    output logic                        done,
    output logic signed [31:0]          quot
);

    logic [DIV_Q_W-1:0]   dvd_reg;
    logic [DIV_DEN_W-2:0] rem_reg;
    logic [DIV_DEN_W-2:0] den_reg;
    logic                 neg_reg;
    logic [5:0]           cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [31:0]          num_abs;
    logic [DIV_DEN_W-1:0] trial;
    logic [DIV_DEN_W:0]   diff;
    logic                 fits;

    assign num_abs = num[31] ? -num : num;
    assign trial = {rem_reg, dvd_reg[DIV_Q_W-1]};
    assign diff = {1'b0, trial} - {2'b00, den_reg};
    assign fits = !diff[DIV_DEN_W];
    assign busy = busy_reg;
    assign done = done_reg;

    // Truncation toward zero, then saturation to 32 signed bits.
    always_comb
    begin
        if (neg_reg)
        begin
            if ((|dvd_reg[DIV_Q_W-1:32]) || (dvd_reg[31] && (|dvd_reg[30:0])))
                quot = 32'sh8000_0000;
            else
                quot = -$signed(dvd_reg[31:0]);
        end
        else
        begin
            if (|dvd_reg[DIV_Q_W-1:31])
                quot = 32'sh7fff_ffff;
            else
                quot = $signed(dvd_reg[31:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'(DIV_Q_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= {num_abs, 30'd0};
            rem_reg <= '0;
            den_reg <= den[DIV_DEN_W-2:0];
            neg_reg <= num[31];
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DIV_DEN_W-2:0] : trial[DIV_DEN_W-2:0];
            dvd_reg <= {dvd_reg[DIV_Q_W-2:0], fits};
        end
    end

endmodule
